// ===== sv/u2da_pkg.sv =====
// Shared types, constants and helper functions for the decimal ASCII converter.
package u2da_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int FIELD_BITS     = 32;
  localparam int NUM_DIGITS     = 10;
  localparam int DIGIT_BITS     = 4;
  localparam int CHAR_BITS      = 6;
  localparam int IDX_BITS       = $clog2(NUM_DIGITS);
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CHAR_BITS-DIGIT_BITS-1:0] ASCII_ZERO_HI = 2'b11;

  typedef logic [DIGIT_BITS-1:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] bcd_digits_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] value;
    logic                  is_zero;
  } item_t;

  typedef struct packed {
    bcd_digits_t digits;
    logic        is_zero;
  } bcd_t;

  function automatic int conv_bits(int value_bits);
    return (value_bits > FIELD_BITS) ? FIELD_BITS : value_bits;
  endfunction

  function automatic logic [FIELD_BITS-1:0] value_mask(int value_bits);
    logic [63:0] m;
    m = (64'd1 << conv_bits(value_bits)) - 64'd1;
    return m[FIELD_BITS-1:0];
  endfunction

  function automatic bcd_digits_t dabble_step(bcd_digits_t d, logic bit_in);
    bcd_digits_t                       adj;
    logic [NUM_DIGITS*DIGIT_BITS:0]    wide;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (d[i] >= 4'd5) ? d[i] + 4'd3 : d[i];
    end
    wide = {adj, bit_in};
    return wide[NUM_DIGITS*DIGIT_BITS-1:0];
  endfunction

  function automatic logic [IDX_BITS-1:0] msd_index(bcd_digits_t d);
    logic [IDX_BITS-1:0] idx;
    idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (d[i] != '0) begin
        idx = IDX_BITS'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== sv/u2da_front.sv =====
// Input stage: takes a value, masks it and flags zero before queueing.
module u2da_front #(
  parameter int VALUE_BITS = u2da_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [u2da_pkg::FIELD_BITS-1:0] value,
  output logic                            push_valid,
  input  logic                            push_ready,
  output u2da_pkg::item_t                 push_item
);
  import u2da_pkg::*;

  localparam logic [FIELD_BITS-1:0] VALUE_MASK = value_mask(VALUE_BITS);

  logic                  full;
  item_t                 item;
  logic [FIELD_BITS-1:0] masked;
  logic                  accept;

  assign masked     = value & VALUE_MASK;
  assign in_stall   = full && !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push_valid = full;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (push_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.value   <= masked;
      item.is_zero <= (masked == '0);
    end
  end

endmodule

// ===== sv/u2da_queue.sv =====
// Short queue between the input stage and the converter.
module u2da_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  u2da_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output u2da_pkg::item_t pop_item
);
  import u2da_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

  item_t               entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                push;
  logic                pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== sv/u2da_conv.sv =====
// Double-dabble converter: one binary bit shifted into the BCD digits per cycle.
module u2da_conv #(
  parameter int VALUE_BITS = u2da_pkg::VALUE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  u2da_pkg::item_t pop_item,
  output logic            res_valid,
  input  logic            res_ready,
  output u2da_pkg::bcd_t  res
);
  import u2da_pkg::*;

  localparam int CONV_BITS = conv_bits(VALUE_BITS);
  localparam int STEP_BITS = $clog2(CONV_BITS);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(CONV_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SHIFT = 3'b010,
    S_DONE  = 3'b100
  } state_t;

  state_t                state;
  logic [FIELD_BITS-1:0] bin;
  bcd_digits_t           digits;
  logic                  is_zero;
  logic [STEP_BITS-1:0]  step;

  assign pop_ready   = (state == S_IDLE);
  assign res_valid   = (state == S_DONE);
  assign res.digits  = digits;
  assign res.is_zero = is_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            state <= pop_item.is_zero ? S_DONE : S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (step == LAST_STEP) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && pop_valid) begin
      bin     <= pop_item.value << (FIELD_BITS - CONV_BITS);
      digits  <= '0;
      is_zero <= pop_item.is_zero;
      step    <= '0;
    end else if (state == S_SHIFT) begin
      digits <= dabble_step(digits, bin[FIELD_BITS-1]);
      bin    <= bin << 1;
      step   <= step + 1'b1;
    end
  end

endmodule

// ===== sv/u2da_emit.sv =====
// Digit emitter: drops leading zeros and sends ASCII digits, most significant first.
module u2da_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           res_valid,
  output logic                           res_ready,
  input  u2da_pkg::bcd_t                 res,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [u2da_pkg::CHAR_BITS-1:0] digit_char,
  output logic                           last
);
  import u2da_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEND = 2'b10
  } state_t;

  state_t              state;
  bcd_digits_t         digits;
  logic [IDX_BITS-1:0] idx;
  logic                load_out;

  assign res_ready = (state == S_IDLE);
  assign load_out  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= (state == S_SEND);
      end
      unique case (state)
        S_IDLE: begin
          if (res_valid) begin
            state <= S_SEND;
          end
        end
        S_SEND: begin
          if (load_out && idx == '0) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && res_valid) begin
      digits <= res.digits;
      idx    <= msd_index(res.digits);
    end else if (state == S_SEND && load_out) begin
      digit_char <= {ASCII_ZERO_HI, digits[idx]};
      last       <= (idx == '0);
      if (idx != '0) begin
        idx <= idx - 1'b1;
      end
    end
  end

endmodule

// ===== sv/unsigned_to_decimal_ascii_top.sv =====
// Unsigned binary to decimal ASCII converter, top level.
// A value passes the input stage, the queue, the double-dabble loop (one step
// per bit), the emitter and its output register before its first digit leaves.
// The converter takes a new value only once the emitter has taken its result;
// zero inputs skip the shift loop. Digits leave at one per cycle unless stalled.
// Reset clears all control state; no clearing pass is needed.
module unsigned_to_decimal_ascii_top #(
  parameter int VALUE_BITS = u2da_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [u2da_pkg::FIELD_BITS-1:0] value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [u2da_pkg::CHAR_BITS-1:0]  digit_char,
  output logic                            last
);
  import u2da_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;
  logic  res_valid;
  logic  res_ready;
  bcd_t  res;

  u2da_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  u2da_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  u2da_conv #(
    .VALUE_BITS (VALUE_BITS)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  u2da_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last       (last)
  );

  a_front_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> push_valid)
    else $error("input transfer lost in front stage");

  a_nonzero_digits: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.is_zero) |-> (res.digits != '0))
    else $error("nonzero value converted to all-zero digits");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> out_valid)
    else $error("digit run broken before last digit");

endmodule

// ===== tb/sv/tb_unsigned_to_decimal_ascii_top.sv =====
// Self-checking testbench for the unsigned to decimal ASCII converter.
module tb_unsigned_to_decimal_ascii_top;
  import u2da_pkg::*;

  localparam int CONV_BITS    = VALUE_BITS_DEF;
  localparam int MAX_DIGITS   = NUM_DIGITS;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 6'd48;
  localparam int DEC_BASE     = 10;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_SHOWN    = 10;
  localparam int RANDOM_ITEMS = 80;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last;
  } digit_result_t;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic [FIELD_BITS-1:0] value      = '0;
  logic                  out_stall  = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [CHAR_BITS-1:0]  digit_char;
  logic                  last;

  digit_result_t pending_digits[$];
  digit_result_t oldest_digit;
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  logic          tx_idle_en     = 1'b1;
  logic          rx_idle_en     = 1'b1;
  logic          hold_req       = 1'b0;
  logic          hold_seen      = 1'b0;
  int            hold_left      = 0;
  int            stall_left     = 0;

  unsigned_to_decimal_ascii_top #(
    .VALUE_BITS(CONV_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digit_char(digit_char),
    .last      (last)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pow10(int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * DEC_BASE;
    return p;
  endfunction

  task automatic predict_decimal(input logic [FIELD_BITS-1:0] v);
    logic [63:0]           mask;
    logic [FIELD_BITS-1:0] rem;
    logic [3:0]            digs[MAX_DIGITS];
    int                    n;
    digit_result_t         r;
    mask = (64'd1 << CONV_BITS) - 64'd1;
    rem  = v & mask[FIELD_BITS-1:0];
    n    = 0;
    do begin
      digs[n] = 4'(rem % DEC_BASE);
      n++;
      rem = rem / DEC_BASE;
    end while (rem != 0 && n < MAX_DIGITS);
    for (int i = n - 1; i >= 0; i--) begin
      r.digit_char = CHAR_ZERO + CHAR_BITS'(digs[i]);
      r.last       = (i == 0);
      pending_digits.push_back(r);
    end
  endtask

  task automatic send_value(input logic [FIELD_BITS-1:0] v);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_decimal(v);
  endtask

  task automatic test_extremes();
    logic [FIELD_BITS-1:0] list[$];
    list = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
             32'd1000000000, 32'd999999999, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h5555_5555, 32'hAAAA_AAAA, 32'd123456789, 32'd4000000000};
    foreach (list[i]) send_value(list[i]);
  endtask

  task automatic test_zero_burst();
    tx_idle_en  = 1'b0;
    rx_idle_en <= 1'b0;
    repeat (4) send_value(32'd0);
    send_value(32'd1);
    send_value(32'd0);
    send_value(32'd9);
    send_value(32'd0);
    tx_idle_en  = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  task automatic test_random_values();
    logic [FIELD_BITS-1:0] v;
    logic [63:0]           p;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 30 == 29) begin
        tx_idle_en  = ($urandom_range(0, 2) != 0);
        rx_idle_en <= ($urandom_range(0, 2) != 0);
      end
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $urandom >> $urandom_range(0, 31);
        2: begin
          p = pow10($urandom_range(1, 9));
          v = FIELD_BITS'(p - 64'($urandom_range(0, 1)));
        end
        default: v = $urandom_range(0, 99);
      endcase
      send_value(v);
    end
    tx_idle_en  = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  task automatic test_output_hold_off();
    tx_idle_en = 1'b0;
    hold_req  <= ~hold_req;
    repeat (20) send_value($urandom);
    tx_idle_en = 1'b1;
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // check each output transfer against the oldest expected digit
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_digits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected digit: char=%0d last=%0b", digit_char, last);
      end else begin
        oldest_digit = pending_digits.pop_front();
        if (digit_char !== oldest_digit.digit_char || last !== oldest_digit.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("digit mismatch: expected char=%0d last=%0b, got char=%0d last=%0b",
                     oldest_digit.digit_char, oldest_digit.last, digit_char, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_zero_burst();
    test_random_values();
    test_output_hold_off();
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_digits.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
